@@ hw/rtl/lsw_pkg.sv @@
// Shared types and constants for the lidar beam to world point block.
// No dependencies.
`timescale 1ns / 1ps

package lsw_pkg;

   localparam int CordicSteps = 14;
   localparam int StepWidth   = 4;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_RANGE_LO = 2'd0;
   localparam logic [1:0] CSR_RANGE_HI = 2'd1;

   // opcodes
   localparam logic OP_POSE = 1'b0;
   localparam logic OP_BEAM = 1'b1;

   // 1/K of the CORDIC, Q2.30
   localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

   // reciprocal of 45 with 28 fraction bits
   localparam logic [22:0] RECIP_45 = 23'd5965233;

   // datapath commands from the controller
   typedef struct packed {
      logic                 load;
      logic                 pose_mul;
      logic                 pose_sum;
      logic                 vec_step;
      logic                 pose_end;
      logic                 beam_div;
      logic                 beam_ang;
      logic                 rot_step;
      logic                 mul_lo;
      logic                 mul_hi;
      logic                 sel_y;
      logic                 place;
      logic [StepWidth-1:0] step;
   } lsw_cmd_type;

   // arctangent of 2^-i in 1/65536 turn
   function automatic logic [15:0] atan_turn(input logic [StepWidth-1:0] i);
      logic [15:0] t;
      unique case (i)
         4'd0:    t = 16'd8192;
         4'd1:    t = 16'd4836;
         4'd2:    t = 16'd2555;
         4'd3:    t = 16'd1297;
         4'd4:    t = 16'd651;
         4'd5:    t = 16'd326;
         4'd6:    t = 16'd163;
         4'd7:    t = 16'd81;
         4'd8:    t = 16'd41;
         4'd9:    t = 16'd20;
         4'd10:   t = 16'd10;
         4'd11:   t = 16'd5;
         4'd12:   t = 16'd3;
         4'd13:   t = 16'd1;
         default: t = 16'd0;
      endcase
      return t;
   endfunction

endpackage

@@ hw/rtl/lsw_ctrl.sv @@
// Controller state machine: sequences pose updates and beams through the datapath.
// Depends on lsw_pkg.
`timescale 1ns / 1ps

module lsw_ctrl import lsw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output lsw_cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PMUL  = 4'd1;
   localparam logic [3:0] S_PSUM  = 4'd2;
   localparam logic [3:0] S_VEC   = 4'd3;
   localparam logic [3:0] S_PEND  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_ANG   = 4'd6;
   localparam logic [3:0] S_ROT   = 4'd7;
   localparam logic [3:0] S_XL    = 4'd8;
   localparam logic [3:0] S_XH    = 4'd9;
   localparam logic [3:0] S_YL    = 4'd10;
   localparam logic [3:0] S_YH    = 4'd11;
   localparam logic [3:0] S_PLACE = 4'd12;

   localparam logic [StepWidth-1:0] LastStep = StepWidth'(CordicSteps - 1);

   logic [3:0]           state_ff, state_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.step     = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_opcode == OP_POSE) ? S_PMUL : S_DIV;
            end
         end
         S_PMUL: begin
            cmd.pose_mul = 1'b1;
            state_in     = S_PSUM;
         end
         S_PSUM: begin
            cmd.pose_sum = 1'b1;
            step_in      = '0;
            state_in     = S_VEC;
         end
         S_VEC: begin
            cmd.vec_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LastStep) state_in = S_PEND;
         end
         S_PEND: begin
            cmd.pose_end = 1'b1;
            state_in     = S_IDLE;
         end
         S_DIV: begin
            cmd.beam_div = 1'b1;
            state_in     = S_ANG;
         end
         S_ANG: begin
            cmd.beam_ang = 1'b1;
            step_in      = '0;
            state_in     = S_ROT;
         end
         S_ROT: begin
            cmd.rot_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LastStep) state_in = S_XL;
         end
         S_XL: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_XH;
         end
         S_XH: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_YL;
         end
         S_YL: begin
            cmd.mul_lo = 1'b1;
            cmd.sel_y  = 1'b1;
            state_in   = S_YH;
         end
         S_YH: begin
            cmd.mul_hi = 1'b1;
            cmd.sel_y  = 1'b1;
            state_in   = S_PLACE;
         end
         S_PLACE: begin
            // wait until the output register is free
            if (out_free) begin
               cmd.place    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/lsw_datapath.sv @@
// Datapath: pose state, range bounds, vectoring and rotation CORDIC, offset multiply.
// Depends on lsw_pkg.
`timescale 1ns / 1ps

module lsw_datapath import lsw_pkg::*; #(
   parameter int BEAM_COUNT = 360
) (
   input  logic               clock,
   input  logic               reset,
   input  lsw_cmd_type        cmd,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_opcode,
   input  logic [8:0]         req_beam_index,
   input  logic [31:0]        req_beam_range,
   input  logic signed [31:0] req_new_pos_x,
   input  logic signed [31:0] req_new_pos_y,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic               rsp_point_valid,
   output logic [8:0]         rsp_point_index
);

   // configuration and pose state
   logic [31:0]        lo_bound_ff, hi_bound_ff;
   logic signed [31:0] pose_x_ff, pose_y_ff;
   logic [15:0]        heading_ff;
   logic [15:0]        vang_ff;
   logic               vzero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_bound_ff <= '0;
         hi_bound_ff <= '1;
         pose_x_ff   <= '0;
         pose_y_ff   <= '0;
         heading_ff  <= '0;
      end else begin
         if (csr_write && csr_index == CSR_RANGE_LO) lo_bound_ff <= csr_data;
         if (csr_write && csr_index == CSR_RANGE_HI) hi_bound_ff <= csr_data;
         if (cmd.load && req_opcode == OP_POSE) begin
            pose_x_ff <= req_new_pos_x;
            pose_y_ff <= req_new_pos_y;
         end
         if (cmd.pose_end) heading_ff <= vzero_ff ? 16'd0 : vang_ff;
      end
   end

   // captured transaction
   logic [8:0]         idx_ff;
   logic [31:0]        range_ff;
   logic               ok_ff;
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic               ok_in;

   assign ok_in = (32'(req_beam_index) < 32'(BEAM_COUNT)) &&
                  (req_beam_range >= lo_bound_ff) && (req_beam_range <= hi_bound_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff   <= req_beam_index;
         range_ff <= req_beam_range;
         ok_ff    <= ok_in;
         qw_ff    <= req_quat_w;
         qx_ff    <= req_quat_x;
         qy_ff    <= req_quat_y;
         qz_ff    <= req_quat_z;
      end
   end

   // quaternion products
   logic signed [31:0] pwz_ff, pxy_ff, pyy_ff, pzz_ff;

   always_ff @(posedge clock) begin
      if (cmd.pose_mul) begin
         pwz_ff <= qw_ff * qz_ff;
         pxy_ff <= qx_ff * qy_ff;
         pyy_ff <= qy_ff * qy_ff;
         pzz_ff <= qz_ff * qz_ff;
      end
   end

   // vectoring CORDIC for the heading
   logic signed [36:0] vx_ff, vy_ff, vx_in, vy_in;
   logic [15:0]        vang_in;
   logic               vzero_in;
   logic signed [36:0] sn, cs, vxs, vys;
   logic [15:0]        tval;

   assign tval = atan_turn(cmd.step);
   assign sn   = (37'(pwz_ff) + 37'(pxy_ff)) <<< 1;
   assign cs   = 37'sd268435456 - ((37'(pyy_ff) + 37'(pzz_ff)) <<< 1);
   assign vxs  = vx_ff >>> cmd.step;
   assign vys  = vy_ff >>> cmd.step;

   always_comb begin
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      vang_in  = vang_ff;
      vzero_in = vzero_ff;
      if (cmd.pose_sum) begin
         vzero_in = (sn == '0) && (cs == '0);
         if (cs < 0) begin
            vx_in   = -cs;
            vy_in   = -sn;
            vang_in = 16'd32768;
         end else begin
            vx_in   = cs;
            vy_in   = sn;
            vang_in = 16'd0;
         end
      end else if (cmd.vec_step) begin
         if (vy_ff > 0) begin
            vx_in   = vx_ff + vys;
            vy_in   = vy_ff - vxs;
            vang_in = vang_ff + tval;
         end else begin
            vx_in   = vx_ff - vys;
            vy_in   = vy_ff + vxs;
            vang_in = vang_ff - tval;
         end
      end
   end

   always_ff @(posedge clock) begin
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      vang_ff  <= vang_in;
      vzero_ff <= vzero_in;
   end

   // beam angle step: (index*8192 + 22) / 45 by reciprocal
   logic [21:0] num;
   logic [44:0] qprod;
   logic [15:0] bstep_ff;

   assign num   = {idx_ff, 13'd0} + 22'd22;
   assign qprod = 45'(num) * 45'(RECIP_45);

   always_ff @(posedge clock) begin
      if (cmd.beam_div) bstep_ff <= qprod[43:28];
   end

   // rotation CORDIC for cos/sin
   logic [15:0]        ang;
   logic signed [16:0] zraw;
   logic signed [33:0] rx_ff, ry_ff, rx_in, ry_in, rxs, rys;
   logic signed [16:0] rz_ff, rz_in;
   logic               neg_ff, neg_in;

   assign ang  = heading_ff + bstep_ff;
   assign zraw = 17'($signed(ang));
   assign rxs  = rx_ff >>> cmd.step;
   assign rys  = ry_ff >>> cmd.step;

   always_comb begin
      rx_in  = rx_ff;
      ry_in  = ry_ff;
      rz_in  = rz_ff;
      neg_in = neg_ff;
      if (cmd.beam_ang) begin
         rx_in = CORDIC_GAIN_INV;
         ry_in = '0;
         if (zraw > 17'sd16384) begin
            rz_in  = zraw - 17'sd32768;
            neg_in = 1'b1;
         end else if (zraw < -17'sd16384) begin
            rz_in  = zraw + 17'sd32768;
            neg_in = 1'b1;
         end else begin
            rz_in  = zraw;
            neg_in = 1'b0;
         end
      end else if (cmd.rot_step) begin
         if (rz_ff >= 0) begin
            rx_in = rx_ff - rys;
            ry_in = ry_ff + rxs;
            rz_in = rz_ff - $signed({1'b0, tval});
         end else begin
            rx_in = rx_ff + rys;
            ry_in = ry_ff - rxs;
            rz_in = rz_ff + $signed({1'b0, tval});
         end
      end
   end

   always_ff @(posedge clock) begin
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      rz_ff  <= rz_in;
      neg_ff <= neg_in;
   end

   // offset = (range * trig + 2^29) >> 30, range split in two 16-bit halves
   logic signed [33:0] trig_raw, trig;
   logic [15:0]        half;
   logic signed [50:0] pp;
   logic signed [50:0] acc_ff;
   logic signed [66:0] full;
   logic signed [36:0] offx_ff, offy_ff;

   assign trig_raw = cmd.sel_y ? ry_ff : rx_ff;
   assign trig     = neg_ff ? -trig_raw : trig_raw;
   assign half     = cmd.mul_hi ? range_ff[31:16] : range_ff[15:0];
   assign pp       = $signed({1'b0, half}) * trig;
   assign full     = 67'(acc_ff) + (67'(pp) <<< 16) + 67'sd536870912;

   always_ff @(posedge clock) begin
      if (cmd.mul_lo) acc_ff <= pp;
      if (cmd.mul_hi && !cmd.sel_y) offx_ff <= full[66:30];
      if (cmd.mul_hi && cmd.sel_y)  offy_ff <= full[66:30];
   end

   // add to pose and saturate
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                  input logic signed [36:0] o);
      logic signed [37:0] v;
      v = 38'(p) + 38'(o);
      if (v > 38'sd2147483647)       return 32'sh7fffffff;
      else if (v < -38'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         rsp_point_x     <= ok_ff ? sat_add(pose_x_ff, offx_ff) : '0;
         rsp_point_y     <= ok_ff ? sat_add(pose_y_ff, offy_ff) : '0;
         rsp_point_valid <= ok_ff;
         rsp_point_index <= idx_ff;
      end
   end

endmodule

@@ hw/rtl/lidar_scan_to_world_points_top.sv @@
// Top level of the lidar beam to world point block.
// Depends on lsw_pkg, lsw_ctrl and lsw_datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    opcode, beam and pose fields
//   rsp      out        rsp_valid/rsp_ready    point_x/y, point_valid, point_index
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One transaction at a time. A beam result passes the beam angle division, the 14-step
// rotation CORDIC and four 16x34 multiplies, and is placed once the output register
// is free; the next transaction is accepted after that. A pose update passes the
// quaternion products and the 14-step vectoring CORDIC before the next acceptance.
// A finished result sits in the output register, and the next transaction is
// accepted while it waits. Reset is synchronous; csr writes are always ready.
`timescale 1ns / 1ps

module lidar_scan_to_world_points_top import lsw_pkg::*; #(
   parameter int BEAM_COUNT = 360
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [8:0]         req_beam_index,
   input  logic [31:0]        req_beam_range,
   input  logic signed [31:0] req_new_pos_x,
   input  logic signed [31:0] req_new_pos_y,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic               rsp_point_valid,
   output logic [8:0]         rsp_point_index,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   lsw_cmd_type cmd;

   assign csr_ready = 1'b1;

   lsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd)
   );

   lsw_datapath #(
      .BEAM_COUNT (BEAM_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_opcode      (req_opcode),
      .req_beam_index  (req_beam_index),
      .req_beam_range  (req_beam_range),
      .req_new_pos_x   (req_new_pos_x),
      .req_new_pos_y   (req_new_pos_y),
      .req_quat_w      (req_quat_w),
      .req_quat_x      (req_quat_x),
      .req_quat_y      (req_quat_y),
      .req_quat_z      (req_quat_z),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_valid (rsp_point_valid),
      .rsp_point_index (rsp_point_index)
   );

endmodule

@@ dv/tb_lidar_scan_to_world_points_top.sv @@
// Self-checking testbench for lidar_scan_to_world_points_top: pose updates and beams
// are predicted in the bench and compared against every response. Depends on lsw_pkg.
`timescale 1ns / 1ps

module tb_lidar_scan_to_world_points_top import lsw_pkg::*; ();

   localparam int NumBeams = 360;
   localparam int CycleLimit = 2000000;

   typedef struct packed {
      logic        opcode;
      logic [8:0]  beam_index;
      logic [31:0] beam_range;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [15:0] qw;
      logic [15:0] qx;
      logic [15:0] qy;
      logic [15:0] qz;
   } scan_item_type;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic        pvalid;
      logic [8:0]  pindex;
   } world_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = 1'b0;
   logic [8:0] req_beam_index = '0;
   logic [31:0] req_beam_range = '0;
   logic signed [31:0] req_new_pos_x = '0;
   logic signed [31:0] req_new_pos_y = '0;
   logic signed [15:0] req_quat_w = '0;
   logic signed [15:0] req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic rsp_point_valid;
   logic [8:0] rsp_point_index;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   lidar_scan_to_world_points_top #(.BEAM_COUNT(NumBeams)) u_dut (.*);

   always #2 clock = ~clock;

   // predictor state and configuration
   logic [31:0] range_lo_q = 32'd0;
   logic [31:0] range_hi_q = 32'hFFFF_FFFF;
   logic [31:0] robot_x = '0;
   logic [31:0] robot_y = '0;
   logic [15:0] robot_heading = '0;

   scan_item_type   pending_items[$];
   world_point_type expected_points[$];

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int hold_off_cycles = 0;
   int mismatch_count = 0;
   int point_count = 0;
   int valid_point_count = 0;
   int accepted_count = 0;
   longint cycle_count = 0;

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic int turn_step(int i);
      int tbl[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
      return tbl[i];
   endfunction

   // vectoring CORDIC: heading from the quaternion terms
   function automatic logic [15:0] heading_from_terms(longint sy, longint cx);
      longint xv, yv, xs, ys;
      int ang;
      xv = cx; yv = sy; ang = 0;
      if (xv == 0 && yv == 0) return 16'd0;
      if (xv < 0) begin
         xv = -xv; yv = -yv; ang = 32768;
      end
      for (int i = 0; i < 14; i++) begin
         xs = asr(xv, i); ys = asr(yv, i);
         if (yv > 0) begin
            xv += ys; yv -= xs; ang += turn_step(i);
         end else begin
            xv -= ys; yv += xs; ang -= turn_step(i);
         end
      end
      return ang[15:0];
   endfunction

   // rotation CORDIC: Q2.30 cos and sin of a binary-turn angle
   function automatic void cos_sin_of(logic [15:0] a, output longint c, output longint s);
      int z;
      bit flip;
      longint xv, yv, xs, ys;
      z = int'($signed(a)); flip = 0; xv = 652032874; yv = 0;
      if (z > 16384) begin
         z -= 32768; flip = 1;
      end else if (z < -16384) begin
         z += 32768; flip = 1;
      end
      for (int i = 0; i < 14; i++) begin
         xs = asr(xv, i); ys = asr(yv, i);
         if (z >= 0) begin
            xv -= ys; yv += xs; z -= turn_step(i);
         end else begin
            xv += ys; yv -= xs; z += turn_step(i);
         end
      end
      c = flip ? -xv : xv;
      s = flip ? -yv : yv;
   endfunction

   function automatic logic [31:0] offset_point(logic [31:0] pos, logic [31:0] rng, longint trig);
      longint off, v;
      off = asr(longint'({32'd0, rng}) * trig + (64'sd1 <<< 29), 30);
      v = longint'($signed(pos)) + off;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   // update pose state or queue the expected world point
   function automatic void predict_point(scan_item_type it);
      longint w, x, y, z, c, s;
      world_point_type p;
      logic [15:0] a;
      int unsigned st;
      if (it.opcode == OP_POSE) begin
         w = $signed(it.qw); x = $signed(it.qx); y = $signed(it.qy); z = $signed(it.qz);
         robot_x = it.pos_x;
         robot_y = it.pos_y;
         robot_heading = heading_from_terms(2 * (w * z + x * y),
                                            (64'sd1 <<< 28) - 2 * (y * y + z * z));
         return;
      end
      p = '0;
      p.pindex = it.beam_index;
      if (it.beam_index < NumBeams && it.beam_range >= range_lo_q
          && it.beam_range <= range_hi_q) begin
         st = (it.beam_index * 8192 + 22) / 45;
         a = robot_heading + st[15:0];
         cos_sin_of(a, c, s);
         p.px = offset_point(robot_x, it.beam_range, c);
         p.py = offset_point(robot_y, it.beam_range, s);
         p.pvalid = 1'b1;
      end
      expected_points.push_back(p);
   endfunction

   // driver
   always @(posedge clock) begin
      scan_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) accepted_count++;
         if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            it = pending_items.pop_front();
            predict_point(it);
            req_valid      <= 1'b1;
            req_opcode     <= it.opcode;
            req_beam_index <= it.beam_index;
            req_beam_range <= it.beam_range;
            req_new_pos_x  <= it.pos_x;
            req_new_pos_y  <= it.pos_y;
            req_quat_w     <= it.qw;
            req_quat_x     <= it.qx;
            req_quat_y     <= it.qy;
            req_quat_z     <= it.qz;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: check each response transaction against the oldest expectation
   always @(posedge clock) begin
      world_point_type e;
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) begin
         point_count++;
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response x=%h y=%h v=%b i=%0d", rsp_point_x,
                        rsp_point_y, rsp_point_valid, rsp_point_index);
         end else begin
            e = expected_points.pop_front();
            if (e.pvalid) valid_point_count++;
            if (rsp_point_x !== e.px || rsp_point_y !== e.py ||
                rsp_point_valid !== e.pvalid || rsp_point_index !== e.pindex) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch exp x=%h y=%h v=%b i=%0d got x=%h y=%h v=%b i=%0d",
                           e.px, e.py, e.pvalid, e.pindex, rsp_point_x, rsp_point_y,
                           rsp_point_valid, rsp_point_index);
            end
         end
      end
   end

   // receiver ready, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_lidar_scan_to_world_points_top: FAIL");
         $finish;
      end
   end

   function automatic scan_item_type pose_item(logic [31:0] x, logic [31:0] y,
                                               logic [15:0] w, logic [15:0] qx,
                                               logic [15:0] qy, logic [15:0] qz);
      scan_item_type it;
      it = '{opcode: OP_POSE, beam_index: 9'($urandom), beam_range: $urandom,
             pos_x: x, pos_y: y, qw: w, qx: qx, qy: qy, qz: qz};
      return it;
   endfunction

   function automatic scan_item_type beam_item(logic [8:0] idx, logic [31:0] rng);
      scan_item_type it;
      it = '{opcode: OP_BEAM, beam_index: idx, beam_range: rng, pos_x: $urandom,
             pos_y: $urandom, qw: 16'($urandom), qx: 16'($urandom), qy: 16'($urandom),
             qz: 16'($urandom)};
      return it;
   endfunction

   // mostly modest ranges and poses, with occasional full-width values
   function automatic scan_item_type random_item();
      logic [31:0] rng, px, py;
      logic [15:0] w, z;
      if ($urandom_range(9) < 2) begin
         if ($urandom_range(3) == 0) begin
            w = 16'($urandom); z = 16'($urandom);
            return pose_item($urandom, $urandom, w, 16'($urandom), 16'($urandom), z);
         end
         px = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(2000000)) - 1000000;
         py = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(2000000)) - 1000000;
         w = 16'($urandom_range(32767)); z = 16'($signed($urandom_range(32767)) - 16384);
         return pose_item(px, py, w, 16'($urandom_range(2000) - 1000),
                          16'($urandom_range(2000) - 1000), z);
      end
      rng = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h00FF_FFFF);
      return beam_item(9'($urandom_range(9) == 0 ? $urandom : $urandom_range(NumBeams - 1)),
                       rng);
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_points.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_range(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_RANGE_LO) range_lo_q = val;
      else range_hi_q = val;
      @(posedge clock);
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) pending_items.push_back(random_item());
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero quaternion, extremes, unused fields, bounds and index limits
      pending_items.push_back(beam_item(9'd0, 32'h0001_0000));
      pending_items.push_back(pose_item(32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      pending_items.push_back(beam_item(9'd359, 32'hFFFF_FFFF));
      pending_items.push_back(beam_item(9'd360, 32'h0001_0000));
      pending_items.push_back(beam_item(9'd511, 32'h0));
      pending_items.push_back(pose_item(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF,
                                        16'h0, 16'h0, 16'h0));
      pending_items.push_back(beam_item(9'd0, 32'hFFFF_FFFF));
      pending_items.push_back(beam_item(9'd180, 32'hFFFF_FFFF));
      pending_items.push_back(beam_item(9'd90, 32'hFFFF_FFFF));
      pending_items.push_back(beam_item(9'd270, 32'hFFFF_FFFF));
      pending_items.push_back(pose_item(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000,
                                        16'h8000, 16'h8000, 16'h8000));
      pending_items.push_back(beam_item(9'd45, 32'hFFFF_FFFF));
      pending_items.push_back(pose_item(32'h0001_0000, 32'hFFFF_0000, 16'h0,
                                        16'h7FFF, 16'h7FFF, 16'h0));
      pending_items.push_back(beam_item(9'd1, 32'h0000_8000));
      pending_items.push_back(pose_item(32'h0, 32'h0, 16'h2D41, 16'h0, 16'h0, 16'hD2BF));
      pending_items.push_back(beam_item(9'd135, 32'h0064_0000));
      wait_drained();

      write_range(CSR_RANGE_LO, 32'h0001_0000);
      write_range(CSR_RANGE_HI, 32'h0010_0000);
      pending_items.push_back(beam_item(9'd10, 32'h0000_FFFF));
      pending_items.push_back(beam_item(9'd10, 32'h0001_0000));
      pending_items.push_back(beam_item(9'd10, 32'h0010_0000));
      pending_items.push_back(beam_item(9'd10, 32'h0010_0001));
      wait_drained();
      // crossed bounds: every beam invalid
      write_range(CSR_RANGE_LO, 32'hFFFF_FFFF);
      write_range(CSR_RANGE_HI, 32'h0);
      pending_items.push_back(beam_item(9'd20, 32'h0));
      pending_items.push_back(beam_item(9'd20, 32'hFFFF_FFFF));
      wait_drained();

      // random phases under changing idling and bounds
      write_range(CSR_RANGE_LO, 32'h0000_4000);
      write_range(CSR_RANGE_HI, 32'h00C0_0000);
      sender_idle_pct = 20; receiver_idle_pct = 82;
      random_phase(500);

      write_range(CSR_RANGE_LO, 32'h0);
      write_range(CSR_RANGE_HI, 32'hFFFF_FFFF);
      sender_idle_pct = 82; receiver_idle_pct = 20;
      random_phase(500);

      // receiver holds off while the sender keeps offering, filling the block
      sender_idle_pct = 0; receiver_idle_pct = 0;
      hold_off_cycles = 300;
      random_phase(500);

      while (req_valid) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d transactions accepted, %0d points checked (%0d valid)",
               accepted_count, point_count, valid_point_count);
      $display("bounds extremes, crossed bounds, pose extremes and long output stall exercised");
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("tb_lidar_scan_to_world_points_top: PASS");
      end else begin
         $display("%0d mismatches, %0d points outstanding", mismatch_count,
                  expected_points.size());
         $display("tb_lidar_scan_to_world_points_top: FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/lsw_pkg.sv
hw/rtl/lsw_ctrl.sv
hw/rtl/lsw_datapath.sv
hw/rtl/lidar_scan_to_world_points_top.sv
dv/tb_lidar_scan_to_world_points_top.sv
